// ===== hdl/tle_pkg.sv =====
`timescale 1ns / 1ps
package tle_pkg;

  localparam logic [31:0] MASTER_KEY = 32'h4A5E6A29;
  localparam logic [31:0] USER_KEY   = 32'hDC89ED79;

  localparam int HOLD_W    = 16;
  localparam int MARK_W    = 33;
  // now (32 bit unsigned) minus mark (33 bit unsigned), signed
  localparam int ELAPSED_W = 35;

  // shared compare unit operations: lhs multiple of elapsed against rhs multiple of hold
  localparam logic [1:0] CMP_E_H    = 2'd0;  // e  vs h
  localparam logic [1:0] CMP_10E_8H = 2'd1;  // 10e vs 8h
  localparam logic [1:0] CMP_10E_5H = 2'd2;  // 10e vs 5h
  localparam logic [1:0] CMP_E_2H   = 2'd3;  // e  vs 2h

  typedef struct packed {
    logic done;
    logic found;
    logic master;
    logic free_found;
  } scan_res_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_res_t;

endpackage

// ===== hdl/tle_time_cmp.sv =====
`timescale 1ns / 1ps
module tle_time_cmp import tle_pkg::*; (
  input  logic                        clk,
  input  logic signed [ELAPSED_W-1:0] elapsed,
  input  logic [HOLD_W-1:0]           hold,
  input  logic [1:0]                  op,
  output cmp_res_t                    res
);

  logic signed [ELAPSED_W+3:0] e_ext;
  logic signed [ELAPSED_W+3:0] lhs;
  logic [HOLD_W+2:0]           rhs;
  logic signed [ELAPSED_W+4:0] diff;

  always_comb begin
    e_ext = {{4{elapsed[ELAPSED_W-1]}}, elapsed};
    unique case (op)
      CMP_E_H: begin
        lhs = e_ext;
        rhs = {3'b000, hold};
      end
      CMP_10E_8H: begin
        lhs = (e_ext <<< 3) + (e_ext <<< 1);
        rhs = {hold, 3'b000};
      end
      CMP_10E_5H: begin
        lhs = (e_ext <<< 3) + (e_ext <<< 1);
        rhs = {1'b0, hold, 2'b00} + {3'b000, hold};
      end
      CMP_E_2H: begin
        lhs = e_ext;
        rhs = {2'b00, hold, 1'b0};
      end
      default: begin
        lhs = e_ext;
        rhs = {3'b000, hold};
      end
    endcase
    diff = {lhs[ELAPSED_W+3], lhs} - $signed({{(ELAPSED_W+5-(HOLD_W+3)){1'b0}}, rhs});
  end

  always_ff @(posedge clk) begin
    res.gt <= !diff[ELAPSED_W+4] && (diff != '0);
    res.lt <= diff[ELAPSED_W+4];
  end

endmodule

// ===== hdl/tle_key_scan.sv =====
`timescale 1ns / 1ps
module tle_key_scan import tle_pkg::*; #(
  parameter int KEY_SLOTS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  uid,
  input  logic                         wr_en,
  input  logic [$clog2(KEY_SLOTS)-1:0] wr_idx,
  input  logic [31:0]                  wr_data,
  output scan_res_t                    res,
  output logic [$clog2(KEY_SLOTS)-1:0] free_idx
);

  localparam int SW = $clog2(KEY_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(KEY_SLOTS - 1);

  logic [31:0]          key_mem [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] key_vld_r;
  logic                 iss_busy_r;
  logic [SW-1:0]        iss_cnt_r;
  logic [31:0]          rd_q_r;
  logic                 stg_vld_r;
  logic [SW-1:0]        stg_idx_r;
  logic                 stg_kv_r;
  logic                 done_r;
  logic                 found_r;
  logic                 master_r;
  logic                 free_found_r;
  logic [SW-1:0]        free_idx_r;
  logic [31:0]          stg_key;
  logic                 stg_hit;

  // slots 0 and 1 are valid from reset and never written, so they read as constants
  always_comb begin
    if (stg_idx_r == SW'(0)) begin
      stg_key = MASTER_KEY;
    end else if (stg_idx_r == SW'(1)) begin
      stg_key = USER_KEY;
    end else begin
      stg_key = rd_q_r;
    end
    stg_hit = stg_kv_r && (stg_key == uid);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_data;
    end
    if (iss_busy_r) begin
      rd_q_r <= key_mem[iss_cnt_r];
    end
    stg_idx_r <= iss_cnt_r;
    stg_kv_r  <= key_vld_r[iss_cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r    <= KEY_SLOTS'(2'b11);
      iss_busy_r   <= 1'b0;
      iss_cnt_r    <= '0;
      stg_vld_r    <= 1'b0;
      done_r       <= 1'b0;
      found_r      <= 1'b0;
      master_r     <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      done_r    <= stg_vld_r && (stg_idx_r == LAST_IDX);
      stg_vld_r <= iss_busy_r;
      if (wr_en) begin
        key_vld_r[wr_idx] <= 1'b1;
      end
      if (start) begin
        iss_busy_r   <= 1'b1;
        iss_cnt_r    <= '0;
        found_r      <= 1'b0;
        master_r     <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (iss_busy_r) begin
          iss_cnt_r <= iss_cnt_r + SW'(1);
          if (iss_cnt_r == LAST_IDX) begin
            iss_busy_r <= 1'b0;
          end
        end
        if (stg_vld_r) begin
          // first match wins
          if (stg_hit && !found_r) begin
            found_r  <= 1'b1;
            master_r <= (stg_idx_r == SW'(0));
          end
          if (!stg_kv_r && (stg_idx_r != SW'(0)) && !free_found_r) begin
            free_found_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld_r && !stg_kv_r && (stg_idx_r != SW'(0)) && !free_found_r) begin
      free_idx_r <= stg_idx_r;
    end
  end

  assign res.done       = done_r;
  assign res.found      = found_r;
  assign res.master     = master_r;
  assign res.free_found = free_found_r;
  assign free_idx       = free_idx_r;

`ifndef SYNTH
  a_wr_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !key_vld_r[wr_idx])
    else $error("key write into a slot that is already valid");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !iss_busy_r && !stg_vld_r)
    else $error("scan reported done with reads still in flight");
`endif

endmodule

// ===== hdl/tag_lock_enroll_controller.sv =====
`timescale 1ns / 1ps
// Tag lock with master-tag enrollment.
// Input channel (in_valid / in_stall): one reader poll per transaction, carrying
// the tag-present flag, the tag UID and the current time in ms.
// Output channel (out_valid / out_stall): one status transaction per poll with
// the lock mode, the open flag and the rejected-key flag.
// Configuration channel (cfg_valid / cfg_ready): writes the base hold time in
// ms; write it only while no poll is in progress.
// A poll with a tag scans the key slots, one key memory read per cycle, then
// makes four passes through one shared time compare unit, an update and an
// output load. A poll without a tag skips the scan.
// in_stall is high from acceptance until the status is loaded into the output
// register. If the receiver stalls, the status waits there and the next poll
// runs up to its output load, where it holds until the register frees up.
// Reset: lock open, mode unlocked, master and user keys in slots 0 and 1,
// other slots empty, hold time 1500 ms, time mark zero.
module tag_lock_enroll_controller import tle_pkg::*; #(
  parameter int KEY_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_tag_present,
  input  logic [31:0]       in_tag_uid,
  input  logic [31:0]       in_now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_lock_state,
  output logic              out_is_open,
  output logic              out_bad_key,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HOLD_W-1:0] cfg_hold_ms
);

  localparam int SW = $clog2(KEY_SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_C1   = 4'd2;
  localparam logic [3:0] S_C2   = 4'd3;
  localparam logic [3:0] S_C3   = 4'd4;
  localparam logic [3:0] S_C4   = 4'd5;
  localparam logic [3:0] S_C5   = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [1:0] MODE_UNLOCKED = 2'd0;
  localparam logic [1:0] MODE_LOCKED   = 2'd1;
  localparam logic [1:0] MODE_AWAIT    = 2'd2;
  localparam logic [1:0] MODE_ENROLLED = 2'd3;

  localparam logic [HOLD_W-1:0] HOLD_RESET    = 16'd1500;
  localparam logic [MARK_W-1:0] TIMEOUT_DELAY = 33'd1000;

  logic [3:0]                  state_r, state_nxt;
  logic [HOLD_W-1:0]           hold_r;
  logic                        open_r, open_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic                        pend_r, pend_nxt;
  logic                        ms_r, ms_nxt;
  logic [MARK_W-1:0]           mark_r, mark_nxt;
  logic                        rej_r, rej_nxt;
  logic                        out_valid_r;
  logic [1:0]                  out_mode_r;
  logic                        out_open_r;
  logic                        out_rej_r;

  logic                        present_r;
  logic [31:0]                 uid_r;
  logic [31:0]                 now_r;
  logic signed [ELAPSED_W-1:0] elapsed_r;
  logic                        gt_h_r, lt_h_r, gt08_r, gt05_r, lt2h_r, gt2h_r;

  logic                        in_acc;
  logic                        out_load;
  logic                        scan_start;
  scan_res_t                   scan_res;
  logic [SW-1:0]               free_idx;
  logic [1:0]                  cmp_op;
  cmp_res_t                    cmp_res;
  logic                        auth;
  logic                        do_toggle, do_enter, do_store;
  logic                        key_wr;

  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign scan_start = in_acc && in_tag_present;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  tle_key_scan #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .uid      (uid_r),
    .wr_en    (key_wr),
    .wr_idx   (free_idx),
    .wr_data  (uid_r),
    .res      (scan_res),
    .free_idx (free_idx)
  );

  tle_time_cmp u_cmp (
    .clk     (clk),
    .elapsed (elapsed_r),
    .hold    (hold_r),
    .op      (cmp_op),
    .res     (cmp_res)
  );

  always_comb begin
    unique case (state_r)
      S_C2:    cmp_op = CMP_10E_8H;
      S_C3:    cmp_op = CMP_10E_5H;
      S_C4:    cmp_op = CMP_E_2H;
      default: cmp_op = CMP_E_H;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tag_present ? S_SCAN : S_C1;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_C1;
        end
      end
      S_C1:   state_nxt = S_C2;
      S_C2:   state_nxt = S_C3;
      S_C3:   state_nxt = S_C4;
      S_C4:   state_nxt = S_C5;
      S_C5:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // All thresholds use the elapsed time at entry: any step that moves the
  // mark to now leaves zero elapsed, which passes none of the later checks.
  always_comb begin
    open_nxt  = open_r;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    ms_nxt    = ms_r;
    mark_nxt  = mark_r;
    rej_nxt   = rej_r;
    auth      = present_r && scan_res.found;
    do_toggle = 1'b0;
    do_enter  = 1'b0;
    do_store  = 1'b0;
    if (present_r) begin
      if (auth) begin
        ms_nxt = scan_res.master;
      end
      do_toggle = !pend_r && auth && gt_h_r;
      do_enter  = !do_toggle && !pend_r && ms_nxt && auth && gt08_r && lt_h_r;
      do_store  = !do_toggle && !do_enter && pend_r && !auth && gt05_r && lt2h_r;
      if (do_toggle) begin
        open_nxt = !open_r;
        mark_nxt = {1'b0, now_r};
        mode_nxt = open_r ? MODE_LOCKED : MODE_UNLOCKED;
      end else if (do_enter) begin
        pend_nxt = 1'b1;
        ms_nxt   = 1'b0;
        mark_nxt = {1'b0, now_r};
        mode_nxt = MODE_AWAIT;
      end else if (do_store) begin
        pend_nxt = 1'b0;
        mark_nxt = {1'b0, now_r};
        mode_nxt = MODE_ENROLLED;
      end
      rej_nxt = !auth && (mode_nxt != MODE_AWAIT) && (mode_nxt != MODE_ENROLLED);
    end
    // enroll timeout
    if (!do_toggle && !do_enter && !do_store && gt2h_r &&
        ((mode_nxt == MODE_AWAIT) || (mode_nxt == MODE_ENROLLED))) begin
      pend_nxt = 1'b0;
      mode_nxt = open_nxt ? MODE_UNLOCKED : MODE_LOCKED;
      mark_nxt = {1'b0, now_r} + TIMEOUT_DELAY;
    end
  end

  // a full table drops the new key but still completes the enroll
  assign key_wr = (state_r == S_UPD) && do_store && scan_res.free_found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_r      <= HOLD_RESET;
      open_r      <= 1'b1;
      mode_r      <= MODE_UNLOCKED;
      pend_r      <= 1'b0;
      ms_r        <= 1'b0;
      mark_r      <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        hold_r <= cfg_hold_ms;
      end
      if (state_r == S_UPD) begin
        open_r <= open_nxt;
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        ms_r   <= ms_nxt;
        mark_r <= mark_nxt;
        rej_r  <= rej_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      present_r <= in_tag_present;
      uid_r     <= in_tag_uid;
      now_r     <= in_now_ms;
      elapsed_r <= $signed({3'b000, in_now_ms}) - $signed({2'b00, mark_r});
    end
    unique case (state_r)
      S_C2: begin
        gt_h_r <= cmp_res.gt;
        lt_h_r <= cmp_res.lt;
      end
      S_C3: gt08_r <= cmp_res.gt;
      S_C4: gt05_r <= cmp_res.gt;
      S_C5: begin
        lt2h_r <= cmp_res.lt;
        gt2h_r <= cmp_res.gt;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_mode_r <= mode_r;
      out_open_r <= open_r;
      out_rej_r  <= rej_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lock_state = out_mode_r;
  assign out_is_open    = out_open_r;
  assign out_bad_key    = out_rej_r;

`ifndef SYNTH
  a_pend_is_await: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (mode_r == MODE_AWAIT))
    else $error("enroll pending outside the awaiting mode");

  a_store_in_enroll: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |-> pend_r && !scan_res.found)
    else $error("key stored outside enroll or for a known tag");
`endif

endmodule
